[sv/pot_average_lock_hysteresis_defines.svh]
// Assertion macros for the potentiometer conditioner checker.
// Standalone header; expects clk and arst_n in the scope of use.
`ifndef POT_AVERAGE_LOCK_HYSTERESIS_DEFINES_SVH
`define POT_AVERAGE_LOCK_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pal_pkg.sv]
// Shared types and constants for the potentiometer conditioner.
// No dependencies.
package pal_pkg;

	localparam int AVG_LOG2  = 3;
	localparam int AVG_DEPTH = 1 << AVG_LOG2;
	localparam int THRESH_W  = 12;
	localparam int HOLD_W    = 8;
	localparam int MEAN_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [THRESH_W-1:0] MOVE_THRESHOLD_RST = 12'd20;
	localparam logic [THRESH_W-1:0] LOCK_THRESHOLD_RST = 12'd40;
	localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST     = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOVE_THRESHOLD = 2'd0,
		REG_LOCK_THRESHOLD = 2'd1,
		REG_HOLD_TICKS     = 2'd2
	} reg_idx_t;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_LOCK   = 1'b1
	} func_t;

	typedef struct packed {
		logic [THRESH_W-1:0] move_threshold;
		logic [THRESH_W-1:0] lock_threshold;
		logic [HOLD_W-1:0]   hold_ticks;
	} cfg_t;

endpackage

[sv/pot_average_lock_hysteresis.sv]
// Potentiometer conditioner top level: 8-sample moving average with
// hysteresis on reported changes and a pickup lock.
// Depends on pal_pkg, pal_front, pal_queue and pal_back.
//
// Input channel (in_valid / in_stall): each item carries func and sample.
//   A sample item (func 0) enters the ring; a lock item (func 1) captures
//   the current mean as the lock position and clears the settle counter.
// Output channel (out_valid / out_stall): one result per item, in order:
//   mean_value, value_changed, is_locked, is_active.
// Configuration: write cfg_data to register cfg_index on a cycle with
//   cfg_write high; 0 move threshold, 1 lock threshold, 2 hold ticks.
//   Other indexes are ignored. Write only while the block is idle.
// Throughput: one item per cycle while the queue has room. The ring keeps
//   a running sum, so the mean costs one add and subtract in the front;
//   the back needs one compare pair.
// Path: an accepted item goes from the front into the queue, then from
//   the back into the output register, where it waits out any stall.
// Stalls: the two-entry queue lets the front keep taking items while a
//   result waits; in_stall rises only once the queue is full.
// Reset: clears the ring, sum, lock and settle state, empties the queue and
//   loads register defaults of 20, 40 and 50. No clearing pass is needed.
module pot_average_lock_hysteresis #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [pal_pkg::MEAN_W-1:0] mean_value,
	output logic                   value_changed,
	output logic                   is_locked,
	output logic                   is_active,
	input  logic                   cfg_write,
	input  logic [pal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pal_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pal_pkg::*;

	localparam int QW = SAMPLE_BITS + 1;

	cfg_t                   cfg_q;
	logic                   q_full;
	logic                   q_valid;
	logic                   q_pop;
	logic                   accept;
	logic [SAMPLE_BITS-1:0] front_mean;
	logic [QW-1:0]          q_rd;

	// Register file; keep only the low bits of each write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_threshold <= MOVE_THRESHOLD_RST;
			cfg_q.lock_threshold <= LOCK_THRESHOLD_RST;
			cfg_q.hold_ticks     <= HOLD_TICKS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MOVE_THRESHOLD: cfg_q.move_threshold <= cfg_data[THRESH_W-1:0];
				REG_LOCK_THRESHOLD: cfg_q.lock_threshold <= cfg_data[THRESH_W-1:0];
				REG_HOLD_TICKS:     cfg_q.hold_ticks     <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Take an item whenever the queue has room.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	pal_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.func   (func),
		.sample (sample),
		.mean   (front_mean)
	);

	pal_queue #(
		.W(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({func, front_mean}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd),
		.not_empty (q_valid)
	);

	pal_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_func        (q_rd[QW-1]),
		.q_mean        (q_rd[SAMPLE_BITS-1:0]),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mean_value    (mean_value),
		.value_changed (value_changed),
		.is_locked     (is_locked),
		.is_active     (is_active)
	);

endmodule

[sv/pal_queue.sv]
// Two-entry queue between the averaging front and the hysteresis back.
// Depends on nothing; width set by parameter.
module pal_queue #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         not_empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[sv/pal_front.sv]
// Front end: takes items, updates the sample ring and running sum, forms the mean.
// Depends on pal_pkg.
module pal_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   func,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] mean
);
	import pal_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + AVG_LOG2;

	logic [SAMPLE_BITS-1:0] ring_q [AVG_DEPTH];
	logic [AVG_LOG2-1:0]    idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       sum_nxt;
	logic                   is_sample;

	assign is_sample = (func == FUNC_SAMPLE);

	// Swap the oldest entry out of the running sum.
	assign sum_nxt = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(sample);

	// Lock items see the current mean; samples see it after the swap.
	assign mean = is_sample ? sum_nxt[SUM_W-1:AVG_LOG2] : sum_q[SUM_W-1:AVG_LOG2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			idx_q <= '0;
			sum_q <= '0;
		end else if (accept && is_sample) begin
			ring_q[idx_q] <= sample;
			idx_q         <= idx_q + AVG_LOG2'(1);
			sum_q         <= sum_nxt;
		end
	end

endmodule

[sv/pal_back.sv]
// Back end: lock and hysteresis state, settle counter, output register.
// Depends on pal_pkg.
module pal_back #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pal_pkg::cfg_t          cfg,
	input  logic                   q_valid,
	input  logic                   q_func,
	input  logic [SAMPLE_BITS-1:0] q_mean,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [pal_pkg::MEAN_W-1:0] mean_value,
	output logic                   value_changed,
	output logic                   is_locked,
	output logic                   is_active
);
	import pal_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	logic                   locked_q;
	logic [SAMPLE_BITS-1:0] last_q;
	logic [SAMPLE_BITS-1:0] lock_pos_q;
	logic [HOLD_W-1:0]      settle_q;
	logic                   out_valid_q;
	logic [MEAN_W-1:0]      mean_q;
	logic                   changed_q;
	logic                   locked_out_q;
	logic                   active_q;

	logic [CMP_W-1:0]       m_ext;
	logic [CMP_W-1:0]       last_ext;
	logic [CMP_W-1:0]       pos_ext;
	logic [CMP_W-1:0]       move_diff;
	logic [CMP_W-1:0]       lock_diff;
	logic                   moved;
	logic                   escaped;

	logic                   locked_nxt;
	logic [SAMPLE_BITS-1:0] last_nxt;
	logic [SAMPLE_BITS-1:0] lock_pos_nxt;
	logic [HOLD_W-1:0]      settle_nxt;
	logic                   changed_nxt;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	assign m_ext     = CMP_W'(q_mean);
	assign last_ext  = CMP_W'(last_q);
	assign pos_ext   = CMP_W'(lock_pos_q);
	assign move_diff = (m_ext > last_ext) ? (m_ext - last_ext) : (last_ext - m_ext);
	assign lock_diff = (m_ext > pos_ext) ? (m_ext - pos_ext) : (pos_ext - m_ext);
	assign moved     = move_diff > CMP_W'(cfg.move_threshold);
	assign escaped   = lock_diff > CMP_W'(cfg.lock_threshold);

	always_comb begin
		locked_nxt   = locked_q;
		last_nxt     = last_q;
		lock_pos_nxt = lock_pos_q;
		settle_nxt   = settle_q;
		changed_nxt  = 1'b0;
		if (q_func == FUNC_LOCK) begin
			locked_nxt   = 1'b1;
			lock_pos_nxt = q_mean;
			settle_nxt   = '0;
		end else if (locked_q) begin
			if (escaped) begin
				locked_nxt  = 1'b0;
				last_nxt    = q_mean;
				settle_nxt  = cfg.hold_ticks;
				changed_nxt = 1'b1;
			end
		end else if (moved) begin
			last_nxt    = q_mean;
			settle_nxt  = cfg.hold_ticks;
			changed_nxt = 1'b1;
		end else if (settle_q != '0) begin
			settle_nxt = settle_q - HOLD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q    <= 1'b0;
			last_q      <= '0;
			lock_pos_q  <= '0;
			settle_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				locked_q    <= locked_nxt;
				last_q      <= last_nxt;
				lock_pos_q  <= lock_pos_nxt;
				settle_q    <= settle_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mean_q       <= MEAN_W'(q_mean);
			changed_q    <= changed_nxt;
			locked_out_q <= locked_nxt;
			active_q     <= (settle_nxt != '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign mean_value    = mean_q;
	assign value_changed = changed_q;
	assign is_locked     = locked_out_q;
	assign is_active     = active_q;

endmodule

[sv/pal_checker.sv]
// Port-level checks for the potentiometer conditioner, bound to the top level.
// Depends on pal_pkg and pot_average_lock_hysteresis_defines.svh.
`include "pot_average_lock_hysteresis_defines.svh"

module pal_checker #(
	parameter int SAMPLE_BITS = 12
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   func,
	input logic [SAMPLE_BITS-1:0] sample,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [pal_pkg::MEAN_W-1:0] mean_value,
	input logic                   value_changed,
	input logic                   is_locked,
	input logic                   is_active
);

	// A stalled result holds its place and value.
	`PAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(mean_value) && $stable(value_changed), "result dropped while stalled")

	// A stalled input item stays offered and unchanged.
	`PAL_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(func) && $stable(sample), "input item changed while stalled")

	// A report always leaves the block unlocked.
	`PAL_ASSERT_NOW(a_report_unlocked, out_valid && value_changed, !is_locked,
		"report while locked")

	// Locking clears the settle counter and nothing reloads it while locked.
	`PAL_ASSERT_NOW(a_locked_idle, out_valid && is_locked, !is_active,
		"settle counter running while locked")

endmodule

bind pot_average_lock_hysteresis pal_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_pal_checker (.*);

[sim/pal_reading_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the potentiometer conditioner: mirrors the ring average,
// hysteresis, pickup lock and settle counter, and checks each result in order.
// Depends on pal_pkg.
module pal_reading_checker #(
	parameter int SAMPLE_W = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           func,
	input  logic [SAMPLE_W-1:0]            sample,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [pal_pkg::MEAN_W-1:0]     mean_value,
	input  logic                           value_changed,
	input  logic                           is_locked,
	input  logic                           is_active,
	input  logic                           cfg_write,
	input  logic [pal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pal_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             result_count,
	output int                             report_count
);
	import pal_pkg::*;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic              changed;
		logic              locked;
		logic              active;
	} reading_t;

	localparam int MAX_PRINTED = 20;

	cfg_t                cfg;
	logic [SAMPLE_W-1:0] ring [AVG_DEPTH];
	logic [AVG_LOG2-1:0] ring_pos;
	logic [MEAN_W-1:0]   last_report;
	logic                locked;
	logic [MEAN_W-1:0]   lock_pos;
	logic [HOLD_W-1:0]   settle;
	reading_t            expected_readings [$];

	function automatic logic [MEAN_W-1:0] ring_mean();
		logic [SAMPLE_W+AVG_LOG2-1:0] total;
		total = '0;
		for (int i = 0; i < AVG_DEPTH; i++)
			total += ring[i];
		return MEAN_W'(total >> AVG_LOG2);
	endfunction

	function automatic logic [MEAN_W-1:0] distance(input logic [MEAN_W-1:0] a, b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Advance the mirrored state by one item and return the reading it gives.
	function automatic reading_t condition_item(input func_t kind,
			input logic [SAMPLE_W-1:0] raw);
		reading_t r;
		logic [MEAN_W-1:0] avg;
		r.changed = 1'b0;
		if (kind == FUNC_LOCK) begin
			// ring untouched; capture the pickup position
			avg = ring_mean();
			locked = 1'b1;
			lock_pos = avg;
			settle = '0;
		end else begin
			ring[ring_pos] = raw;
			ring_pos = ring_pos + AVG_LOG2'(1);
			avg = ring_mean();
			if (locked) begin
				if (distance(avg, lock_pos) > cfg.lock_threshold) begin
					locked = 1'b0;
					last_report = avg;
					settle = cfg.hold_ticks;
					r.changed = 1'b1;
				end
			end else if (distance(avg, last_report) > cfg.move_threshold) begin
				last_report = avg;
				settle = cfg.hold_ticks;
				r.changed = 1'b1;
			end else if (settle != '0) begin
				settle = settle - HOLD_W'(1);
			end
		end
		r.mean = avg;
		r.locked = locked;
		r.active = (settle != '0);
		return r;
	endfunction

	function automatic void compare_field(input string name,
			input logic [MEAN_W-1:0] want, got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_PRINTED)
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		if (!arst_n) begin
			cfg.move_threshold = MOVE_THRESHOLD_RST;
			cfg.lock_threshold = LOCK_THRESHOLD_RST;
			cfg.hold_ticks = HOLD_TICKS_RST;
			for (int i = 0; i < AVG_DEPTH; i++)
				ring[i] = '0;
			ring_pos = '0;
			last_report = '0;
			locked = 1'b0;
			lock_pos = '0;
			settle = '0;
			expected_readings.delete();
			fail_count = 0;
			result_count = 0;
			report_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_readings.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_PRINTED)
						$display("%0t: unexpected result, expected none, actual mean %0d",
							$time, mean_value);
				end else begin
					want = expected_readings.pop_front();
					compare_field("mean_value", want.mean, mean_value);
					compare_field("value_changed", MEAN_W'(want.changed),
						MEAN_W'(value_changed));
					compare_field("is_locked", MEAN_W'(want.locked), MEAN_W'(is_locked));
					compare_field("is_active", MEAN_W'(want.active), MEAN_W'(is_active));
					if (want.changed)
						report_count++;
				end
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(condition_item(func_t'(func), sample));
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
					REG_MOVE_THRESHOLD: cfg.move_threshold = cfg_data[THRESH_W-1:0];
					REG_LOCK_THRESHOLD: cfg.lock_threshold = cfg_data[THRESH_W-1:0];
					REG_HOLD_TICKS:     cfg.hold_ticks = cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end
		end
		pending = expected_readings.size();
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top of the potentiometer conditioner testbench: clock, reset, item and
// register stimulus, stall patterns and the verdict.
// Depends on pal_pkg, pot_average_lock_hysteresis and pal_reading_checker.
module testbench;
	import pal_pkg::*;

	localparam int SAMPLE_W          = 12;
	localparam int SAMPLE_MAX        = (1 << SAMPLE_W) - 1;
	localparam int ITEMS_PER_SETTING = 221;
	localparam int SETTINGS_PHASES   = 6;
	// covers the block's queue and output register; a little margin on top
	localparam int SETTLE_CYCLES     = 4;
	localparam int LONG_HOLD_CYCLES  = 48;
	// cycles with no handshake on either channel before giving up
	localparam int QUIET_LIMIT       = 1000;

	// index with no register behind it; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	func_t                 func = FUNC_SAMPLE;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [MEAN_W-1:0]     mean_value;
	logic                  value_changed;
	logic                  is_locked;
	logic                  is_active;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MOVE_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int result_count;
	int report_count;

	// idling percentages, read each cycle by the sender and receiver
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	// bumped by the stimulus to ask the receiver for one long hold-off
	int hold_reqs = 0;

	int items_sent = 0;
	int lock_items = 0;
	int settings_used = 1;	// reset defaults count as the first

	pot_average_lock_hysteresis dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mean_value    (mean_value),
		.value_changed (value_changed),
		.is_locked     (is_locked),
		.is_active     (is_active),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pal_reading_checker #(.SAMPLE_W(SAMPLE_W)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mean_value    (mean_value),
		.value_changed (value_changed),
		.is_locked     (is_locked),
		.is_active     (is_active),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.result_count  (result_count),
		.report_count  (report_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls at the current rate, plus a long hold-off of
	// fixed length whenever one is requested. The long one is counted here so
	// the sender keeps offering items and the block's queue fills behind it.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for too
	// long. Reset cycles do not count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offer one item, idling beforehand at the sender's rate, and hold it
	// until the block takes it. Valid stays high into the next item.
	task automatic offer_item(input func_t kind, input logic [SAMPLE_W-1:0] raw);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= kind;
		sample <= raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (kind == FUNC_LOCK)
			lock_items++;
	endtask

	// Drop valid and wait until every expected result has been taken, then
	// let the pipeline settle so the block is idle for register writes.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_write high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] move_val,
			lock_val, hold_val);
		write_reg(REG_MOVE_THRESHOLD, move_val);
		write_reg(REG_LOCK_THRESHOLD, lock_val);
		write_reg(REG_HOLD_TICKS, hold_val);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// Model a hand on the knob: a slowly wandering position with a little
	// converter noise, occasional jumps of small, medium and large size,
	// lock items now and then, and some full-range noise and rail samples.
	task automatic sweep_knob(input int count, input bit squeeze);
		int knob;
		int pick;
		int mag;
		int level;
		knob = $urandom_range(0, SAMPLE_MAX);
		for (int k = 0; k < count; k++) begin
			// ask for the long receiver hold-off a quarter of the way in
			if (squeeze && k == count / 4)
				hold_reqs++;
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				offer_item(FUNC_LOCK, SAMPLE_W'($urandom));
			end else if (pick < 10) begin
				offer_item(FUNC_SAMPLE, SAMPLE_W'($urandom));
			end else if (pick < 13) begin
				offer_item(FUNC_SAMPLE, {SAMPLE_W{pick[0]}});
			end else begin
				if (pick < 25) begin
					case ($urandom_range(0, 2))
						0: mag = $urandom_range(0, 8);
						1: mag = $urandom_range(0, 80);
						default: mag = $urandom_range(0, 1500);
					endcase
					knob += $urandom_range(0, 1) ? mag : -mag;
					knob = knob < 0 ? 0 : knob > SAMPLE_MAX ? SAMPLE_MAX : knob;
				end
				level = knob + int'($urandom_range(0, 6)) - 3;
				level = level < 0 ? 0 : level > SAMPLE_MAX ? SAMPLE_MAX : level;
				offer_item(FUNC_SAMPLE, SAMPLE_W'(level));
			end
		end
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles more lightly than the receiver to begin with.
		tx_idle_pct = 34;
		rx_idle_pct = 60;

		// Directed walk under the reset register values.
		offer_item(FUNC_LOCK, '0);		// lock straight out of reset, mean zero
		offer_item(FUNC_SAMPLE, '0);		// locked and not moved
		repeat (8)
			offer_item(FUNC_SAMPLE, '1);	// unlock, then climb to full scale
		offer_item(FUNC_SAMPLE, '1);		// steady: settle counter counts down
		offer_item(FUNC_LOCK, '0);		// lock at full scale
		offer_item(FUNC_LOCK, '1);		// relock while already locked
		offer_item(FUNC_SAMPLE, '1);		// locked, ring updated, no report
		repeat (8)
			offer_item(FUNC_SAMPLE, '0);	// unlock on the way down to zero
		offer_item(FUNC_SAMPLE, 12'hAAA);
		offer_item(FUNC_SAMPLE, 12'h555);
		offer_item(FUNC_LOCK, 12'h5A5);

		// Random phases, each under its own register setting. The block is
		// drained before each change, which also covers the sender pausing
		// until every expected result has come back.
		for (int p = 0; p < SETTINGS_PHASES; p++) begin
			drain();
			case (p)
				// every comparison strict against zero, no settle time
				0: apply_settings(12'd0, 12'd0, 12'd0);
				// thresholds at the top; hold keeps only its low byte
				1: apply_settings('1, '1, '1);
				2: apply_settings($urandom_range(0, 15), $urandom_range(0, 31),
					$urandom_range(0, 7));
				3: begin
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
					apply_settings($urandom_range(0, 300), $urandom_range(0, 600),
						CFG_DATA_W'($urandom));
				end
				4: apply_settings(12'd3, 12'd8, 12'd1);
				default: apply_settings(MOVE_THRESHOLD_RST, LOCK_THRESHOLD_RST,
					CFG_DATA_W'(HOLD_TICKS_RST));
			endcase
			// swap the idling rates half way, then run flat out
			tx_idle_pct = p < 2 ? 34 : p < 4 ? 60 : 0;
			rx_idle_pct = p < 2 ? 60 : p < 4 ? 34 : 0;
			sweep_knob(ITEMS_PER_SETTING, p == 0 || p == 3);
		end

		drain();

		$display("Ran %0d items, %0d of them locks, under %0d register settings",
			items_sent, lock_items, settings_used);
		$display("and three idling patterns; checked %0d results, %0d reporting a new value.",
			result_count, report_count);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
